FILE: rtl/core/box_blur_3x3_stream_unit_assert.svh
// Assertion macros for the box blur RTL.
`ifndef BOX_BLUR_3X3_STREAM_UNIT_ASSERT_SVH
`define BOX_BLUR_3X3_STREAM_UNIT_ASSERT_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define BBS_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("box blur assertion failed");

// Next-cycle implication, checked at every rising edge out of reset.
`define BBS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("box blur assertion failed");

`endif

FILE: rtl/core/bbs_pkg.sv
// Package of the box blur stream unit: constants, item types and helpers.
`default_nettype none

package bbs_pkg;

  // Line store geometry
  localparam int MAX_WIDTH  = 1024;
  localparam int ADDR_W     = $clog2(MAX_WIDTH);
  localparam int MAX_HEIGHT = 4096;
  localparam int ROW_W      = 12;
  localparam int FW_W       = 11;
  localparam int FH_W       = 13;

  // Output queue: room for every result of the items still in flight
  localparam int MAX_RESULTS = 3;
  localparam int IN_FLIGHT   = 4;
  localparam int QDEPTH      = 16;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  // floor(x/9) = (x * 7282) >> 16 for every 3x3 sum of 8-bit values
  localparam int RECIP_NINE  = 7282;
  localparam int RECIP_SHIFT = 16;

  // Configuration register indexes
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 4'd1;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RESET  = 11'd640;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

  // Channel index 0 is blue, 2 is red
  typedef logic [2:0][7:0] pix_t;
  // Column of the window: 0 is the oldest row, 2 the incoming row
  typedef pix_t [2:0] column_t;
  typedef logic [2:0][9:0] col_sum_t;

  typedef struct packed {
    column_t  col;
    col_sum_t sum;
  } cell_t;

  typedef struct packed {
    pix_t recent;
    pix_t older;
  } line_t;

  typedef struct packed {
    logic [7:0] blue_in;
    logic [7:0] green_in;
    logic [7:0] red_in;
  } pixel_item_t;

  typedef struct packed {
    logic [ROW_W-1:0]  out_row;
    logic [ADDR_W-1:0] out_column;
    logic [7:0]        blue_out;
    logic [7:0]        green_out;
    logic [7:0]        red_out;
    logic              run_last;
  } result_t;

  // Which results an item makes
  typedef struct packed {
    logic lead;      // the pixel one row up and one column left
    logic interior;  // that pixel gets the mean
    logic row_end;   // the last pixel of the row above
    logic last_row;  // the item itself, passed through
  } emit_t;

  // Queue write side: n results in item[0..n-1]
  typedef struct packed {
    logic [1:0]                  n;
    result_t [MAX_RESULTS-1:0]   item;
  } push_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
  } queue_status_t;

  function automatic result_t make_result(logic [ROW_W-1:0] row,
                                          logic [ADDR_W-1:0] col, pix_t p);
    result_t r;
    r.out_row    = row;
    r.out_column = col;
    r.blue_out   = p[0];
    r.green_out  = p[1];
    r.red_out    = p[2];
    r.run_last   = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/bbs_line_ram.sv
// Line store RAM: two previous rows per column, write-first registered read.
`default_nettype none

module bbs_line_ram (
  input  wire logic                 clk,
  input  wire logic                 rd_en,
  input  wire logic [bbs_pkg::ADDR_W-1:0] rd_addr,
  output      bbs_pkg::line_t       rd_data,
  input  wire logic                 wr_en,
  input  wire logic [bbs_pkg::ADDR_W-1:0] wr_addr,
  input  wire bbs_pkg::line_t       wr_data
);
  import bbs_pkg::*;

  line_t mem [MAX_WIDTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; a same-address write is forwarded
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/bbs_cell.sv
// Window cell: one column of the 3x3 window and its per-channel sum.
`default_nettype none

module bbs_cell (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              shift,
  input  wire bbs_pkg::column_t  col_in,
  output      bbs_pkg::cell_t    slot
);
  import bbs_pkg::*;

  col_sum_t sum_next;

  // Column sum of the incoming column
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum_next[ch] = 10'(col_in[0][ch]) + 10'(col_in[1][ch]) + 10'(col_in[2][ch]);
    end
  end

  // Take the incoming column on every shift
  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
    end else if (shift) begin
      slot.col <= col_in;
      slot.sum <= sum_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/bbs_out_queue.sv
// Output queue: takes up to three results a cycle, hands out one while result_ready is high.
`default_nettype none

module bbs_out_queue (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire bbs_pkg::push_t        push,
  output      bbs_pkg::result_t      result,
  output      logic                  result_valid,
  input  wire logic                  result_ready,
  output      bbs_pkg::queue_status_t status
);
  import bbs_pkg::*;

  result_t            q [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               pop;

  assign result_valid = (count != '0);
  assign result       = q[rd_ptr];
  assign pop          = result_valid && result_ready;
  assign status.count = count;

  // Storage
  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_RESULTS; k++) begin
      if (k < int'(push.n)) begin
        q[wr_ptr + QPTR_W'(k)] <= push.item[k];
      end
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push.n);
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push.n) - QCNT_W'(pop);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/box_blur_3x3_stream_unit.sv
// Top level of the 3x3 box blur over a BGR pixel stream.
//
// Pixels enter in raster order on the pixel channel (valid/ready). Each item
// at (r,c) makes up to three results on the result channel, in order: the
// pixel (r-1,c-1), the last pixel of row r-1 at a row end, and the item itself
// on the last row. Interior pixels carry floor(sum/9) per channel, border
// pixels pass through. run_last marks the final result of an item.
// The cfg channel (always ready) writes frame_width (index 0) and
// frame_height (index 1); a write to either restarts the frame at (0,0).
// An item's results pass stage 1 (line store read), the window shift into
// stage 2, the sum in stage 3, then divide by 9 into the output queue.
// Throughput: one item per cycle while the 16-entry output queue holds at
// most 4 results; pixel_ready drops above that, so items that make two or
// three results (row ends, last row) run at the drain rate of the result channel.
// Reset clears the position counters, the window and the queue and loads
// 640x480; the line stores need no clearing. When the receiver stalls the
// queue fills and pixel_ready falls; nothing is lost.
`default_nettype none

`include "box_blur_3x3_stream_unit_assert.svh"

module box_blur_3x3_stream_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          pixel_valid,
  output      logic                          pixel_ready,
  input  wire bbs_pkg::pixel_item_t          pixel,
  output      logic                          result_valid,
  input  wire logic                          result_ready,
  output      bbs_pkg::result_t              result,
  input  wire logic                          cfg_valid,
  output      logic                          cfg_ready,
  input  wire logic [bbs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bbs_pkg::FH_W-1:0]      cfg_data
);
  import bbs_pkg::*;

  logic [FW_W-1:0]   frame_width;
  logic [FH_W-1:0]   frame_height;
  logic [ADDR_W-1:0] w_last;
  logic [ROW_W-1:0]  h_last;
  logic [ROW_W-1:0]  row;
  logic [ADDR_W-1:0] col;
  logic              accept;
  pix_t              pix_in;
  emit_t             flags_in;

  logic              s1_valid;
  logic [ROW_W-1:0]  s1_row;
  logic [ADDR_W-1:0] s1_col;
  pix_t              s1_pix;
  emit_t             s1_flags;
  line_t             rd_line;
  line_t             wr_line;

  column_t           col_feed [3];
  cell_t             cell_q [3];

  logic              s2_valid;
  logic [ROW_W-1:0]  s2_row;
  logic [ADDR_W-1:0] s2_col;
  pix_t              s2_pix;
  pix_t              s2_up1;
  emit_t             s2_flags;

  logic              s3_valid;
  logic [ROW_W-1:0]  s3_row;
  logic [ADDR_W-1:0] s3_col;
  pix_t              s3_pix;
  pix_t              s3_up1;
  pix_t              s3_center;
  emit_t             s3_flags;
  logic [2:0][11:0]  s3_total;
  logic [2:0][11:0]  total_next;

  logic [2:0][24:0]  prod;
  pix_t              mean;
  pix_t              lead_val;
  logic [1:0]        n_res;
  push_t             push;
  queue_status_t     q_status;

  // Effective frame size, clamped to the supported range
  always_comb begin
    if (frame_width == '0) begin
      w_last = '0;
    end else if (frame_width > FW_W'(MAX_WIDTH)) begin
      w_last = ADDR_W'(MAX_WIDTH - 1);
    end else begin
      w_last = ADDR_W'(frame_width - FW_W'(1));
    end
    if (frame_height == '0) begin
      h_last = '0;
    end else if (frame_height > FH_W'(MAX_HEIGHT)) begin
      h_last = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      h_last = ROW_W'(frame_height - FH_W'(1));
    end
  end

  assign cfg_ready   = 1'b1;
  assign pixel_ready = (q_status.count <= QCNT_W'(QDEPTH - MAX_RESULTS * IN_FLIGHT));
  assign accept      = pixel_valid && pixel_ready;
  assign pix_in      = {pixel.red_in, pixel.green_in, pixel.blue_in};

  // Which results the incoming item makes
  always_comb begin
    flags_in.lead     = (row != '0) && (col != '0);
    flags_in.interior = (row >= ROW_W'(2)) && (col >= ADDR_W'(2));
    flags_in.row_end  = (row != '0) && (col == w_last);
    flags_in.last_row = (row == h_last);
  end

  // Configuration registers and raster position
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
      row          <= '0;
      col          <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH: begin
          frame_width <= cfg_data[FW_W-1:0];
          row         <= '0;
          col         <= '0;
        end
        CFG_FRAME_HEIGHT: begin
          frame_height <= cfg_data;
          row          <= '0;
          col          <= '0;
        end
        default: ;
      endcase
    end else if (accept) begin
      if (col == w_last) begin
        col <= '0;
        row <= (row == h_last) ? '0 : row + ROW_W'(1);
      end else begin
        col <= col + ADDR_W'(1);
      end
    end
  end

  // Stage 1 registers: item waits for its line store read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_row   <= row;
      s1_col   <= col;
      s1_pix   <= pix_in;
      s1_flags <= flags_in;
    end
  end

  // Line stores: row above moves to the older slot, item to the recent slot
  assign wr_line.recent = s1_pix;
  assign wr_line.older  = rd_line.recent;

  bbs_line_ram u_line_ram (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col),
    .rd_data (rd_line),
    .wr_en   (s1_valid),
    .wr_addr (s1_col),
    .wr_data (wr_line)
  );

  // Window: three cells, the newest column enters at cell 2
  assign col_feed[2] = {s1_pix, rd_line.recent, rd_line.older};

  for (genvar i = 0; i < 3; i++) begin : g_cell
    if (i < 2) begin : g_link
      assign col_feed[i] = cell_q[i+1].col;
    end
    bbs_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .shift  (s1_valid),
      .col_in (col_feed[i]),
      .slot   (cell_q[i])
    );
  end

  // Stage 2 registers: window holds this item's neighbourhood
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      s2_row   <= s1_row;
      s2_col   <= s1_col;
      s2_pix   <= s1_pix;
      s2_up1   <= rd_line.recent;
      s2_flags <= s1_flags;
    end
  end

  // Neighbourhood sum from the three column sums
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      total_next[ch] = 12'(cell_q[0].sum[ch]) + 12'(cell_q[1].sum[ch])
                     + 12'(cell_q[2].sum[ch]);
    end
  end

  // Stage 3 registers
  always_ff @(posedge clk) begin
    if (s2_valid) begin
      s3_row    <= s2_row;
      s3_col    <= s2_col;
      s3_pix    <= s2_pix;
      s3_up1    <= s2_up1;
      s3_flags  <= s2_flags;
      s3_center <= cell_q[1].col[1];
      s3_total  <= total_next;
    end
  end

  // Divide by nine through the reciprocal
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      prod[ch] = 25'(s3_total[ch]) * 25'(RECIP_NINE);
      mean[ch] = prod[ch][RECIP_SHIFT +: 8];
    end
  end

  assign lead_val = s3_flags.interior ? mean : s3_center;

  // Gather this item's results in order and mark the final one
  always_comb begin
    push  = '0;
    n_res = 2'd0;
    if (s3_valid && s3_flags.lead) begin
      push.item[n_res] = make_result(s3_row - ROW_W'(1), s3_col - ADDR_W'(1), lead_val);
      n_res = n_res + 2'd1;
    end
    if (s3_valid && s3_flags.row_end) begin
      push.item[n_res] = make_result(s3_row - ROW_W'(1), w_last, s3_up1);
      n_res = n_res + 2'd1;
    end
    if (s3_valid && s3_flags.last_row) begin
      push.item[n_res] = make_result(s3_row, s3_col, s3_pix);
      n_res = n_res + 2'd1;
    end
    if (n_res != 2'd0) begin
      push.item[n_res - 2'd1].run_last = 1'b1;
    end
    push.n = n_res;
  end

  bbs_out_queue u_out_queue (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .result       (result),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .status       (q_status)
  );

  // Checks
  `BBS_ASSERT_IMPLY(a_queue_bound, 1'b1, q_status.count <= QCNT_W'(QDEPTH))
  `BBS_ASSERT_IMPLY(a_pos_in_frame, 1'b1, (row <= h_last) && (col <= w_last))
  `BBS_ASSERT_NEXT(a_col_step, accept && !cfg_valid && (col != w_last),
                   col == ADDR_W'($past(col) + ADDR_W'(1)))

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for the 3x3 box blur stream unit: predictor, stimulus and checker.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bbs_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 800_000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned IDLE_PCT      = 7;
  localparam int unsigned RANDOM_ITEMS  = 400;
  localparam int unsigned NEIGHBOURS    = 9;
  localparam int unsigned REPORT_CAP    = 50;
  // Index outside the register map: a write there must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 4'd9;

  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 pixel_valid  = 1'b0;
  logic                 pixel_ready;
  pixel_item_t          pixel        = '0;
  logic                 result_valid;
  logic                 result_ready = 1'b0;
  result_t              result;
  logic                 cfg_valid    = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index    = '0;
  logic [FH_W-1:0]      cfg_data     = '0;

  // calm: no idling on either side while set
  bit          calm            = 1'b0;
  int unsigned cycles          = 0;
  int unsigned mismatches      = 0;
  int unsigned pixels_in       = 0;
  int unsigned results_checked = 0;
  int unsigned settings_used   = 0;

  // Blur predictor state
  bit [23:0]      older_mem [MAX_WIDTH];
  bit [23:0]      recent_mem [MAX_WIDTH];
  bit [23:0]      win [NEIGHBOURS];
  int unsigned    row_pos    = 0;
  int unsigned    col_pos    = 0;
  logic [FW_W-1:0] reg_width  = FRAME_WIDTH_RESET;
  logic [FH_W-1:0] reg_height = FRAME_HEIGHT_RESET;

  // Blurred pixels still owed by the block, oldest first
  result_t due_pixels [$];

  box_blur_3x3_stream_unit uut (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still due", cycles, due_pixels.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver: random back-pressure
  always @(negedge clk) begin
    result_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  task automatic report_bad(input string what, input logic [15:0] want_v,
                            input logic [15:0] got_v);
    mismatches++;
    if (mismatches <= REPORT_CAP)
      $display("MISMATCH cycle %0d: %s want %0d got %0d", cycles, what, want_v, got_v);
  endtask

  task automatic check_field(input string what, input logic [15:0] want_v,
                             input logic [15:0] got_v);
    if (got_v !== want_v) report_bad(what, want_v, got_v);
  endtask

  // Compare every accepted result with the oldest one due
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && result_valid && result_ready) begin
      results_checked++;
      if (due_pixels.size() == 0) begin
        report_bad("result with nothing due, row", '0, 16'(result.out_row));
      end else begin
        want = due_pixels.pop_front();
        check_field("out_row",    16'(want.out_row),    16'(result.out_row));
        check_field("out_column", 16'(want.out_column), 16'(result.out_column));
        check_field("blue_out",   16'(want.blue_out),   16'(result.blue_out));
        check_field("green_out",  16'(want.green_out),  16'(result.green_out));
        check_field("red_out",    16'(want.red_out),    16'(result.red_out));
        check_field("run_last",   16'(want.run_last),   16'(result.run_last));
      end
    end
  end

  function automatic int unsigned used_width();
    if (reg_width == '0) return 1;
    if (32'(reg_width) > MAX_WIDTH) return MAX_WIDTH;
    return 32'(reg_width);
  endfunction

  function automatic int unsigned used_height();
    if (reg_height == '0) return 1;
    if (32'(reg_height) > MAX_HEIGHT) return MAX_HEIGHT;
    return 32'(reg_height);
  endfunction

  // Per-channel floor of the 3x3 sum over nine
  function automatic logic [23:0] nine_mean();
    logic [23:0] res;
    int unsigned sum;
    int ch;
    int i;
    res = '0;
    for (ch = 0; ch < 3; ch++) begin
      sum = 0;
      for (i = 0; i < NEIGHBOURS; i++) sum += 32'(win[i][8*ch +: 8]);
      res[8*ch +: 8] = 8'(sum / NEIGHBOURS);
    end
    return res;
  endfunction

  function automatic result_t shape_result(input int unsigned row, input int unsigned col,
                                           input logic [23:0] px);
    result_t r;
    r.out_row    = ROW_W'(row);
    r.out_column = ADDR_W'(col);
    r.blue_out   = px[7:0];
    r.green_out  = px[15:8];
    r.red_out    = px[23:16];
    r.run_last   = 1'b0;
    return r;
  endfunction

  // Work out the results of one accepted pixel and queue them
  task automatic blur_predict(input pixel_item_t p);
    int unsigned w;
    int unsigned h;
    int unsigned r;
    int unsigned c;
    logic [23:0] px;
    logic [23:0] up2;
    logic [23:0] up1;
    logic [23:0] val;
    result_t     made [3];
    int          n;
    int          k;
    w = used_width();
    h = used_height();
    r = row_pos;
    c = col_pos;
    if (c >= w) c = w - 1;
    if (r >= h) r = h - 1;
    px  = {p.red_in, p.green_in, p.blue_in};
    up2 = older_mem[c];
    up1 = recent_mem[c];
    // shift the window one column left, newest column on the right
    for (k = 0; k < 3; k++) begin
      win[3*k]   = win[3*k+1];
      win[3*k+1] = win[3*k+2];
    end
    win[2] = up2;
    win[5] = up1;
    win[8] = px;
    n = 0;
    if (r >= 1 && c >= 1) begin
      val = (r >= 2 && c >= 2) ? nine_mean() : win[4];
      made[n] = shape_result(r - 1, c - 1, val);
      n++;
    end
    if (r >= 1 && c == w - 1) begin
      made[n] = shape_result(r - 1, w - 1, up1);
      n++;
    end
    if (r == h - 1) begin
      made[n] = shape_result(r, c, px);
      n++;
    end
    if (n > 0) made[n-1].run_last = 1'b1;
    for (k = 0; k < n; k++) due_pixels.push_back(made[k]);
    older_mem[c]  = up1;
    recent_mem[c] = px;
    // raster advance, wrapping after the last pixel of the frame
    if (c == w - 1) begin
      col_pos = 0;
      row_pos = (r == h - 1) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
  endtask

  // Offer one pixel, with random idle cycles ahead of it, and predict on acceptance
  task automatic send_pixel(input pixel_item_t p);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      pixel_valid <= 1'b0;
      @(negedge clk);
    end
    pixel_valid <= 1'b1;
    pixel       <= p;
    do @(posedge clk); while (!pixel_ready);
    blur_predict(p);
    pixels_in++;
  endtask

  // Channels lean towards the extremes now and then
  function automatic pixel_item_t rand_pixel();
    logic [2:0][7:0] ch;
    int unsigned pick;
    int k;
    for (k = 0; k < 3; k++) begin
      pick  = $urandom_range(0, 9);
      ch[k] = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
    end
    return '{blue_in: ch[0], green_in: ch[1], red_in: ch[2]};
  endfunction

  task automatic send_random(input int unsigned n);
    repeat (n) send_pixel(rand_pixel());
  endtask

  // Stop sending, let every due result arrive, then allow for items still in the pipe
  task automatic wait_idle();
    @(negedge clk);
    pixel_valid <= 1'b0;
    while (due_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [FH_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    // either listed register restarts the frame; line stores are kept
    case (index)
      CFG_FRAME_WIDTH: begin
        reg_width = data[FW_W-1:0];
        row_pos   = 0;
        col_pos   = 0;
      end
      CFG_FRAME_HEIGHT: begin
        reg_height = data;
        row_pos    = 0;
        col_pos    = 0;
      end
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_frame(input logic [FH_W-1:0] wdata, input logic [FH_W-1:0] hdata);
    wait_idle();
    write_reg(CFG_FRAME_WIDTH, wdata);
    write_reg(CFG_FRAME_HEIGHT, hdata);
    settings_used++;
  endtask

  // Out of reset the frame is 640 wide: a short first row yields nothing
  task automatic test_reset_geometry();
    send_random(24);
  endtask

  // 3x3 frames: saturated sum, then a mix that exercises rounding down
  task automatic test_blur_directed();
    pixel_item_t p;
    int k;
    set_frame(13'd3, 13'd3);
    for (k = 0; k < 9; k++) send_pixel('{blue_in: 8'hFF, green_in: 8'hFF, red_in: 8'hFF});
    for (k = 0; k < 9; k++) begin
      p.blue_in  = (k % 2) ? 8'hFF : 8'h00;
      p.green_in = 8'(k * k);
      p.red_in   = 8'h80 ^ 8'(k * 37);
      send_pixel(p);
    end
  endtask

  // Frames too narrow or short for any interior pixel, zero sizes clamping to one
  task automatic test_narrow_frames();
    set_frame(13'd0, 13'd0);
    send_random(2);
    set_frame(13'd2, 13'd1);
    send_random(3);
    set_frame(13'd1, 13'd2);
    send_random(3);
  endtask

  // Unmapped index leaves the frame running; a listed write restarts it mid-frame
  task automatic test_restart();
    set_frame(13'd5, 13'd4);
    send_random(8);
    wait_idle();
    write_reg(CFG_SPARE, 13'h1FFF);
    send_random(19);
    wait_idle();
    write_reg(CFG_FRAME_HEIGHT, 13'd4);
    send_random(21);
  endtask

  // Mostly small random frames with random content, a few large or degenerate ones
  task automatic test_random_settings();
    int unsigned sent;
    int unsigned pick;
    int unsigned span;
    int unsigned n;
    logic [FH_W-1:0] wdata;
    logic [FH_W-1:0] hdata;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        wdata = 13'($urandom_range(1, 9));
        hdata = 13'($urandom_range(1, 6));
      end else if (pick < 85) begin
        wdata = 13'($urandom_range(0, 2));
        hdata = 13'($urandom_range(0, 2));
      end else begin
        wdata = 13'($urandom);
        hdata = 13'($urandom);
      end
      set_frame(wdata, hdata);
      span = used_width() * used_height();
      n = (span <= 60) ? $urandom_range(span, 3 * span + used_width()) : $urandom_range(1, 120);
      repeat (n) begin
        calm = (sent >= 180 && sent < 320);
        send_pixel(rand_pixel());
        sent++;
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_geometry();
    test_blur_directed();
    test_narrow_frames();
    test_restart();
    test_random_settings();
    wait_idle();
    $display("Sent %0d pixels over %0d frame geometries (1x1 up to out-of-range sizes),",
             pixels_in, settings_used + 1);
    $display("compared %0d blurred results, %0d mismatches.", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
